// File: sv/nprr_pkg.sv
package nprr_pkg;

  localparam int NODE_W           = 10;
  localparam int FRESH_W          = NODE_W + 1;
  localparam int NEXT_W           = NODE_W + 1;  // ring-in flag on top of the next link
  localparam int SLOTS_MAX        = 1024;
  localparam int POOL_ENTRIES_DEF = 1024;
  localparam logic [NODE_W-1:0] LIVE_MAX = NODE_W'(1023);

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_EMPTY       = 3'd1,
    STAT_IN_RING     = 3'd2,
    STAT_NOT_IN_RING = 3'd3,
    STAT_NULL        = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_READ,
    SEQ_UNLINK,
    SEQ_LINK1,
    SEQ_LINK2,
    SEQ_FIN
  } state_t;

endpackage

// File: sv/node_pool_with_recency_ring.sv
// Node pool with a free list and a circular, doubly linked recency ring.
// Index 0 means no node.
//
// Request channel (req_valid / req_stall): kind and node. A transfer happens
// at a rising edge with req_valid high and req_stall low. Allocate pops the
// free list, or else hands out the next never-used index, and links it at the
// ring head; free unlinks and pushes; insert and remove edit the ring only.
// Response channel (rsp_valid / rsp_stall): one response per request with
// result_node, oldest (ring tail), newest (ring head), live_nodes and status.
//
// Sequencing: the sequencer takes one request at a time. A rejected or failed
// request goes straight to the final step; any other first reads its node's
// links and ring-in flag. A free, remove or allocate of a ringed node unlinks
// it: its own links are written, then its neighbours'. An allocate, after any
// unlink, and an insert of an unringed node link it at the ring head: its own
// links are written, then, unless the ring was empty, the ring is closed.
// Reset (rst, synchronous): a clearing pass over min(POOL_ENTRIES, 1024) slots
// zeroes the ring-in flags; req_stall stays high during it. A stalled response
// holds in its register; the next request is still taken meanwhile and its
// response waits in the final step until the register frees.
module node_pool_with_recency_ring #(
  parameter int POOL_ENTRIES = nprr_pkg::POOL_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  kind,
  input  logic [nprr_pkg::NODE_W-1:0] node,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [nprr_pkg::NODE_W-1:0] result_node,
  output logic [nprr_pkg::NODE_W-1:0] oldest,
  output logic [nprr_pkg::NODE_W-1:0] newest,
  output logic [nprr_pkg::NODE_W-1:0] live_nodes,
  output logic [2:0]                  status
);

  localparam int SLOTS = (POOL_ENTRIES < nprr_pkg::SLOTS_MAX) ? POOL_ENTRIES
                                                               : nprr_pkg::SLOTS_MAX;
  localparam int AW    = $clog2(SLOTS);
  localparam int NW    = nprr_pkg::NODE_W;
  localparam logic [nprr_pkg::FRESH_W-1:0] FRESH_LIM  = nprr_pkg::FRESH_W'(SLOTS);
  localparam logic [AW-1:0]                CLEAR_LAST = AW'(SLOTS - 1);

  nprr_pkg::state_t  state, state_next;
  logic [AW-1:0]     clear_addr;
  logic [NW-1:0]     free_head;
  logic [NW-1:0]     ring_head;
  logic [NW-1:0]     ring_tail;
  logic [NW-1:0]     live_count;
  logic [nprr_pkg::FRESH_W-1:0] fresh_index;

  // Request being worked on
  nprr_pkg::kind_t   op_kind;
  nprr_pkg::status_t op_status;
  logic [NW-1:0]     op_node;
  logic              op_pop;

  // Memory ports
  logic                        nx_we, pv_we, fl_we;
  logic [AW-1:0]               nx_waddr, pv_waddr, fl_waddr;
  logic [nprr_pkg::NEXT_W-1:0] nx_wdata, nx_rdata;
  logic [NW-1:0]               pv_wdata, pv_rdata, fl_wdata, fl_rdata;
  logic                        nx_re, fl_re;
  logic [AW-1:0]               nx_raddr, fl_raddr;

  nprr_pkg::kind_t kind_in;
  logic            req_take;
  logic            pool_hit;
  logic            fresh_ok;
  logic            node_bad;
  logic            alloc_fail;
  logic [NW-1:0]   pick;
  logic            rd_in_ring;
  logic [NW-1:0]   rd_next;
  logic            link_now;
  logic            unlink_now;
  logic            rsp_free;

  assign kind_in    = nprr_pkg::kind_t'(kind);
  assign req_take   = (state == nprr_pkg::SEQ_IDLE) && req_valid;
  assign pool_hit   = (free_head != '0);
  assign fresh_ok   = (fresh_index < FRESH_LIM);
  assign node_bad   = (node == '0) || ({1'b0, node} >= FRESH_LIM);
  assign alloc_fail = !pool_hit && !fresh_ok;
  assign rsp_free   = !rsp_valid || !rsp_stall;

  // Target node: the allocated index on allocate, else the requested node
  always_comb begin
    if (kind_in != nprr_pkg::KIND_ALLOC) begin
      pick = node;
    end else if (pool_hit) begin
      pick = free_head;
    end else begin
      pick = fresh_index[NW-1:0];
    end
  end

  assign rd_in_ring = nx_rdata[NW];
  assign rd_next    = nx_rdata[NW-1:0];
  assign link_now   = !rd_in_ring && ((op_kind == nprr_pkg::KIND_ALLOC) ||
                                      (op_kind == nprr_pkg::KIND_INSERT));
  assign unlink_now = rd_in_ring && (op_kind != nprr_pkg::KIND_INSERT);

  // Next links and ring-in flag share one memory; prev links and free links have their own.
  nprr_ram #(.DEPTH(SLOTS), .WIDTH(nprr_pkg::NEXT_W)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (nx_re),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  nprr_ram #(.DEPTH(SLOTS), .WIDTH(NW)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .re    (nx_re),
    .raddr (nx_raddr),
    .rdata (pv_rdata)
  );

  nprr_ram #(.DEPTH(SLOTS), .WIDTH(NW)) u_free_ram (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .re    (fl_re),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      nprr_pkg::SEQ_CLEAR: begin
        if (clear_addr == CLEAR_LAST) begin
          state_next = nprr_pkg::SEQ_IDLE;
        end
      end
      nprr_pkg::SEQ_IDLE: begin
        if (req_valid) begin
          if ((kind_in == nprr_pkg::KIND_ALLOC) ? alloc_fail : node_bad) begin
            state_next = nprr_pkg::SEQ_FIN;
          end else begin
            state_next = nprr_pkg::SEQ_READ;
          end
        end
      end
      nprr_pkg::SEQ_READ: begin
        if (unlink_now) begin
          state_next = nprr_pkg::SEQ_UNLINK;
        end else if (link_now && (ring_head != '0)) begin
          state_next = nprr_pkg::SEQ_LINK2;
        end else begin
          state_next = nprr_pkg::SEQ_FIN;
        end
      end
      nprr_pkg::SEQ_UNLINK: begin
        state_next = (op_kind == nprr_pkg::KIND_ALLOC) ? nprr_pkg::SEQ_LINK1
                                                       : nprr_pkg::SEQ_FIN;
      end
      nprr_pkg::SEQ_LINK1: begin
        state_next = (ring_head == '0) ? nprr_pkg::SEQ_FIN : nprr_pkg::SEQ_LINK2;
      end
      nprr_pkg::SEQ_LINK2: begin
        state_next = nprr_pkg::SEQ_FIN;
      end
      nprr_pkg::SEQ_FIN: begin
        if (rsp_free) begin
          state_next = nprr_pkg::SEQ_IDLE;
        end
      end
      default: state_next = nprr_pkg::SEQ_CLEAR;
    endcase
  end

  // Sequencer: handshake and memory accesses
  always_comb begin
    req_stall = 1'b1;
    nx_we     = 1'b0;
    nx_waddr  = op_node[AW-1:0];
    nx_wdata  = '0;
    pv_we     = 1'b0;
    pv_waddr  = op_node[AW-1:0];
    pv_wdata  = '0;
    fl_we     = 1'b0;
    fl_waddr  = op_node[AW-1:0];
    fl_wdata  = free_head;
    nx_re     = 1'b0;
    nx_raddr  = pick[AW-1:0];
    fl_re     = 1'b0;
    fl_raddr  = free_head[AW-1:0];
    unique case (state)
      nprr_pkg::SEQ_CLEAR: begin
        // Sweep the next memory so every ring-in flag reads zero
        nx_we    = 1'b1;
        nx_waddr = clear_addr;
      end
      nprr_pkg::SEQ_IDLE: begin
        req_stall = 1'b0;
        nx_re     = req_valid;
        fl_re     = req_valid && (kind_in == nprr_pkg::KIND_ALLOC) && pool_hit;
      end
      nprr_pkg::SEQ_READ: begin
        if (unlink_now) begin
          // Drop the node's own links first; neighbors follow next cycle
          nx_we = 1'b1;
          pv_we = 1'b1;
        end else if (link_now) begin
          nx_we    = 1'b1;
          nx_wdata = {1'b1, (ring_head == '0) ? op_node : ring_head};
          pv_we    = 1'b1;
          pv_wdata = (ring_head == '0) ? op_node : ring_tail;
        end
        fl_we = (op_kind == nprr_pkg::KIND_FREE);
      end
      nprr_pkg::SEQ_UNLINK: begin
        if (rd_next != op_node) begin
          nx_we    = 1'b1;
          nx_waddr = pv_rdata[AW-1:0];
          nx_wdata = {1'b1, rd_next};
          pv_we    = 1'b1;
          pv_waddr = rd_next[AW-1:0];
          pv_wdata = pv_rdata;
        end
      end
      nprr_pkg::SEQ_LINK1: begin
        nx_we    = 1'b1;
        nx_wdata = {1'b1, (ring_head == '0) ? op_node : ring_head};
        pv_we    = 1'b1;
        pv_wdata = (ring_head == '0) ? op_node : ring_tail;
      end
      nprr_pkg::SEQ_LINK2: begin
        // Close the ring around the new head
        nx_we    = 1'b1;
        nx_waddr = ring_tail[AW-1:0];
        nx_wdata = {1'b1, op_node};
        pv_we    = 1'b1;
        pv_waddr = ring_head[AW-1:0];
        pv_wdata = op_node;
      end
      nprr_pkg::SEQ_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nprr_pkg::SEQ_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Pool, ring and request registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr  <= '0;
      free_head   <= '0;
      fresh_index <= nprr_pkg::FRESH_W'(1);
      ring_head   <= '0;
      ring_tail   <= '0;
      live_count  <= '0;
    end else begin
      unique case (state)
        nprr_pkg::SEQ_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
        end
        nprr_pkg::SEQ_IDLE: begin
          if (req_take) begin
            op_kind <= kind_in;
            op_pop  <= (kind_in == nprr_pkg::KIND_ALLOC) && !alloc_fail && pool_hit;
            if (kind_in == nprr_pkg::KIND_ALLOC) begin
              if (alloc_fail) begin
                op_node   <= '0;
                op_status <= nprr_pkg::STAT_EMPTY;
              end else begin
                op_node   <= pick;
                op_status <= nprr_pkg::STAT_OK;
                if (!pool_hit) begin
                  fresh_index <= fresh_index + 1'b1;
                end
                if (live_count < nprr_pkg::LIVE_MAX) begin
                  live_count <= live_count + 1'b1;
                end
              end
            end else begin
              op_node <= node;
              if (node_bad) begin
                op_status <= nprr_pkg::STAT_NULL;
              end else begin
                op_status <= nprr_pkg::STAT_OK;
                if ((kind_in == nprr_pkg::KIND_FREE) && (live_count != '0)) begin
                  live_count <= live_count - 1'b1;
                end
              end
            end
          end
        end
        nprr_pkg::SEQ_READ: begin
          if (op_pop) begin
            free_head <= fl_rdata;
          end
          if (op_kind == nprr_pkg::KIND_FREE) begin
            free_head <= op_node;
          end
          if ((op_kind == nprr_pkg::KIND_INSERT) && rd_in_ring) begin
            op_status <= nprr_pkg::STAT_IN_RING;
          end
          if ((op_kind == nprr_pkg::KIND_REMOVE) && !rd_in_ring) begin
            op_status <= nprr_pkg::STAT_NOT_IN_RING;
          end
          if (link_now && (ring_head == '0)) begin
            ring_head <= op_node;
            ring_tail <= op_node;
          end
        end
        nprr_pkg::SEQ_UNLINK: begin
          if (rd_next == op_node) begin
            ring_head <= '0;
            ring_tail <= '0;
          end else begin
            if (ring_head == op_node) begin
              ring_head <= rd_next;
            end
            if (ring_tail == op_node) begin
              ring_tail <= pv_rdata;
            end
          end
        end
        nprr_pkg::SEQ_LINK1: begin
          if (ring_head == '0) begin
            ring_head <= op_node;
            ring_tail <= op_node;
          end
        end
        nprr_pkg::SEQ_LINK2: begin
          ring_head <= op_node;
        end
        nprr_pkg::SEQ_FIN: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == nprr_pkg::SEQ_FIN) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == nprr_pkg::SEQ_FIN) && rsp_free) begin
      result_node <= op_node;
      oldest      <= ring_tail;
      newest      <= ring_head;
      live_nodes  <= live_count;
      status      <= op_status;
    end
  end

endmodule

// File: sv/nprr_ram.sv
module nprr_ram #(
  parameter int DEPTH = nprr_pkg::SLOTS_MAX,
  parameter int WIDTH = nprr_pkg::NODE_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/nprr_checker.sv
module nprr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic [nprr_pkg::NODE_W-1:0] result_node,
  input logic [nprr_pkg::NODE_W-1:0] oldest,
  input logic [nprr_pkg::NODE_W-1:0] newest,
  input logic [2:0]                  status
);

  // One request at a time: a transfer closes the request side for the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another is in work");

  // A failed allocate reports no node
  a_empty_null: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == nprr_pkg::STAT_EMPTY) |-> (result_node == '0))
    else $error("pool-empty response carries a node");

  // An empty ring head implies an empty ring tail
  a_ring_ends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (newest == '0) |-> (oldest == '0))
    else $error("ring tail present without a head");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(result_node) && $stable(status))
    else $error("stalled response changed");

endmodule

bind node_pool_with_recency_ring nprr_checker u_nprr_checker (.*);
